// ===== rtl/dfps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfps_pkg
// Shared types and constants of the double five-point smoother: request tags,
// divider cell control and the divide-by-35 digit recurrence constants.
// ----------------------------------------------------------------------------
package dfps_pkg;

    localparam int DIV_DIGITS = 4;
    localparam int REM_W = 6;
    localparam logic [REM_W:0] DIVISOR = 7'd35;
    localparam int WIN_TAPS = 7;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] CNT_SAT = 4'd8;

    typedef struct packed {
        logic last;
        logic err;
    } dfps_tag_t;

    typedef struct packed {
        dfps_tag_t tag;
        logic      sat;
    } dfps_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/dfps_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfps_div_cell
// One cell of the divide-by-35 chain: resolves four quotient bits of the
// request it holds and hands the partial remainder and quotient to the next
// cell.
// ----------------------------------------------------------------------------
module dfps_div_cell #(
    parameter int QB = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_ready,
    input  logic [dfps_pkg::REM_W-1:0]     up_rem,
    input  logic [QB-1:0]                  up_work,
    input  dfps_pkg::dfps_ctl_t            up_ctl,
    output logic                           dn_valid,
    input  logic                           dn_ready,
    output logic [dfps_pkg::REM_W-1:0]     dn_rem,
    output logic [QB-1:0]                  dn_work,
    output dfps_pkg::dfps_ctl_t            dn_ctl
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [dfps_pkg::REM_W-1:0] rem_reg;
    logic [dfps_pkg::REM_W-1:0] rem_next;
    logic [QB-1:0]              work_reg;
    logic [QB-1:0]              work_next;
    dfps_pkg::dfps_ctl_t        ctl_reg;
    logic [dfps_pkg::REM_W:0]   trial;

    assign up_ready = !valid_reg || dn_ready;
    assign valid_next = up_ready ? up_valid : valid_reg;

    // restoring division, dividend bits enter at the top of work,
    // quotient bits fill in from the bottom
    always_comb
    begin
        rem_next = up_rem;
        work_next = up_work;
        trial = '0;
        for (int i = 0; i < dfps_pkg::DIV_DIGITS; i++)
        begin
            trial = {rem_next, work_next[QB-1]};
            work_next = {work_next[QB-2:0], 1'b0};
            if (trial >= dfps_pkg::DIVISOR)
            begin
                trial = trial - dfps_pkg::DIVISOR;
                work_next[0] = 1'b1;
            end
            rem_next = trial[dfps_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rem_reg <= rem_next;
            work_reg <= work_next;
            ctl_reg <= up_ctl;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_rem = rem_reg;
    assign dn_work = work_reg;
    assign dn_ctl = ctl_reg;

endmodule
`default_nettype wire

// ===== rtl/dfps_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dfps_stage
// One five-point quadratic smoothing stage: a seven-tap window, the head,
// centre and tail point selection, the weighted numerator and a chain of
// divider cells with clamping.
// ----------------------------------------------------------------------------
module dfps_stage #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   trim,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  logic [SAMPLE_BITS-1:0] up_value,
    input  dfps_pkg::dfps_tag_t    up_tag,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output logic [SAMPLE_BITS-1:0] dn_value,
    output dfps_pkg::dfps_tag_t    dn_tag
);

    localparam int W = SAMPLE_BITS;
    localparam int NUM_W = W + 8;
    localparam int MAG_W = W + 7;
    localparam int NCELL = (W + dfps_pkg::DIV_DIGITS - 1) / dfps_pkg::DIV_DIGITS;
    localparam int QB = NCELL * dfps_pkg::DIV_DIGITS;
    localparam int EXT_W = QB + dfps_pkg::REM_W;
    localparam logic [MAG_W-1:0] LIMIT = MAG_W'(dfps_pkg::DIVISOR) << W;

    localparam logic [2:0] MODE_HEAD0 = 3'd0;
    localparam logic [2:0] MODE_HEAD1 = 3'd1;
    localparam logic [2:0] MODE_CENTRE = 3'd2;
    localparam logic [2:0] MODE_TAIL1 = 3'd3;
    localparam logic [2:0] MODE_TAIL0 = 3'd4;
    localparam logic [2:0] MODE_ERR = 3'd5;

    localparam logic [1:0] OFF_ZERO = 2'd0;
    localparam logic [1:0] OFF_ONE = 2'd1;
    localparam logic [1:0] OFF_TWO = 2'd2;

    localparam logic [dfps_pkg::CNT_W-1:0] CNT_FOUR = 4'd4;
    localparam logic [dfps_pkg::CNT_W-1:0] CNT_FIVE = 4'd5;
    localparam logic [dfps_pkg::CNT_W-1:0] CNT_SIX = 4'd6;
    localparam logic [dfps_pkg::CNT_W-1:0] CNT_SEVEN = 4'd7;

    logic [W-1:0]                 tap_reg [dfps_pkg::WIN_TAPS];
    logic [W-1:0]                 shift_win [dfps_pkg::WIN_TAPS];
    logic [W-1:0]                 win [dfps_pkg::WIN_TAPS];
    logic [W-1:0]                 sel [5];
    logic [W-1:0]                 a [5];
    logic signed [NUM_W-1:0]      e [5];

    logic [dfps_pkg::CNT_W-1:0]   cnt_reg;
    logic [dfps_pkg::CNT_W-1:0]   cnt_next;
    logic                         flush_reg;
    logic                         flush_next;
    logic [1:0]                   step_reg;
    logic [1:0]                   step_next;
    logic [1:0]                   final_step;

    logic                         accept;
    logic                         issue;
    logic [2:0]                   mode;
    logic [1:0]                   off;
    logic                         rev;
    dfps_pkg::dfps_tag_t          tag_iss;
    logic signed [NUM_W-1:0]      num;

    logic                         num_v_reg;
    logic                         num_v_next;
    logic                         num_ready;
    logic signed [NUM_W-1:0]      num_reg;
    logic                         half_reg;
    dfps_pkg::dfps_tag_t          num_tag_reg;

    logic                         neg;
    logic [MAG_W-1:0]             mag;
    logic                         sat;
    logic                         zero;
    logic [EXT_W-1:0]             ext;

    logic                         chain_valid [NCELL+1];
    logic                         chain_ready [NCELL+1];
    logic [dfps_pkg::REM_W-1:0]   chain_rem [NCELL+1];
    logic [QB-1:0]                chain_work [NCELL+1];
    dfps_pkg::dfps_ctl_t          chain_ctl [NCELL+1];

    assign up_ready = !flush_reg && num_ready;
    assign accept = up_valid && up_ready;

    always_comb
    begin
        shift_win[0] = up_value;
        for (int i = 1; i < dfps_pkg::WIN_TAPS; i++)
        begin
            shift_win[i] = tap_reg[i-1];
        end
        for (int i = 0; i < dfps_pkg::WIN_TAPS; i++)
        begin
            win[i] = flush_reg ? tap_reg[i] : shift_win[i];
        end
    end

    // short frames of six or seven points end early on the second stage
    always_comb
    begin
        final_step = 2'd3;
        if (trim && cnt_reg == CNT_SIX)
        begin
            final_step = 2'd2;
        end
        else if (trim && cnt_reg == CNT_SEVEN)
        begin
            final_step = 2'd1;
        end
    end

    always_comb
    begin
        issue = 1'b0;
        mode = MODE_CENTRE;
        off = OFF_TWO;
        tag_iss = '0;
        cnt_next = cnt_reg;
        flush_next = flush_reg;
        step_next = step_reg;
        if (flush_reg)
        begin
            if (num_ready)
            begin
                issue = 1'b1;
                off = OFF_ZERO;
                case (step_reg)
                    2'd0:
                    begin
                        if (cnt_reg == CNT_FIVE)
                        begin
                            mode = MODE_HEAD1;
                        end
                        else
                        begin
                            mode = MODE_CENTRE;
                            off = OFF_ONE;
                        end
                    end
                    2'd1:
                    begin
                        mode = MODE_CENTRE;
                    end
                    2'd2:
                    begin
                        mode = MODE_TAIL1;
                    end
                    default:
                    begin
                        mode = MODE_TAIL0;
                    end
                endcase
                if (step_reg == final_step)
                begin
                    tag_iss.last = 1'b1;
                    flush_next = 1'b0;
                    cnt_next = '0;
                    step_next = 2'd0;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
        end
        else if (accept)
        begin
            if (up_tag.err)
            begin
                issue = 1'b1;
                mode = MODE_ERR;
                tag_iss.last = 1'b1;
                tag_iss.err = 1'b1;
                cnt_next = '0;
            end
            else if (cnt_reg < CNT_FOUR)
            begin
                if (up_tag.last)
                begin
                    issue = 1'b1;
                    mode = MODE_ERR;
                    tag_iss.last = 1'b1;
                    tag_iss.err = 1'b1;
                    cnt_next = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            else
            begin
                issue = 1'b1;
                case (cnt_reg)
                    CNT_FOUR:
                    begin
                        mode = MODE_HEAD0;
                        off = OFF_ZERO;
                    end
                    CNT_FIVE:
                    begin
                        mode = MODE_HEAD1;
                        off = OFF_ONE;
                    end
                    default:
                    begin
                        mode = MODE_CENTRE;
                        off = OFF_TWO;
                    end
                endcase
                if (cnt_reg != dfps_pkg::CNT_SAT)
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
                if (up_tag.last)
                begin
                    flush_next = 1'b1;
                    step_next = 2'd0;
                end
            end
        end
    end

    // five-point window, oldest first; tails use the mirrored head formulas
    always_comb
    begin
        case (off)
            OFF_ONE:
            begin
                sel[0] = win[5];
                sel[1] = win[4];
                sel[2] = win[3];
                sel[3] = win[2];
                sel[4] = win[1];
            end
            OFF_TWO:
            begin
                sel[0] = win[6];
                sel[1] = win[5];
                sel[2] = win[4];
                sel[3] = win[3];
                sel[4] = win[2];
            end
            default:
            begin
                sel[0] = win[4];
                sel[1] = win[3];
                sel[2] = win[2];
                sel[3] = win[1];
                sel[4] = win[0];
            end
        endcase
        rev = (mode == MODE_TAIL1) || (mode == MODE_TAIL0);
        for (int i = 0; i < 5; i++)
        begin
            a[i] = rev ? sel[4-i] : sel[i];
            e[i] = $signed({8'b0, a[i]});
        end
    end

    always_comb
    begin
        case (mode)
            MODE_HEAD0, MODE_TAIL0:
            begin
                num = (e[0] <<< 6) + (e[0] <<< 2) + e[0] + ((e[1] + e[3]) <<< 2)
                    - ((e[2] <<< 2) + (e[2] <<< 1)) - e[4];
            end
            MODE_HEAD1, MODE_TAIL1:
            begin
                num = ((e[0] + e[4]) <<< 1) + (e[1] <<< 4) + (e[1] <<< 3)
                    + (e[1] <<< 1) + e[1] + (e[2] <<< 3) + (e[2] <<< 2) - (e[3] <<< 3);
            end
            MODE_CENTRE:
            begin
                num = ((e[1] + e[3]) <<< 3) + ((e[1] + e[3]) <<< 2) + (e[2] <<< 4) + e[2]
                    - ((e[0] + e[4]) <<< 1) - (e[0] + e[4]);
            end
            default:
            begin
                num = '0;
            end
        endcase
    end

    assign num_ready = !num_v_reg || chain_ready[0];
    assign num_v_next = num_ready ? issue : num_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            flush_reg <= 1'b0;
            step_reg <= 2'd0;
            num_v_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            flush_reg <= flush_next;
            step_reg <= step_next;
            num_v_reg <= num_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < dfps_pkg::WIN_TAPS; i++)
            begin
                tap_reg[i] <= shift_win[i];
            end
        end
        if (num_ready && issue)
        begin
            num_reg <= num;
            half_reg <= (mode == MODE_HEAD0) || (mode == MODE_TAIL0);
            num_tag_reg <= tag_iss;
        end
    end

    // negative quotients clamp to zero, large ones saturate before division
    always_comb
    begin
        neg = num_reg[NUM_W-1];
        mag = half_reg ? {1'b0, num_reg[NUM_W-2:1]} : num_reg[NUM_W-2:0];
        sat = !neg && !num_tag_reg.err && (mag >= LIMIT);
        zero = neg || num_tag_reg.err || sat;
        ext = EXT_W'(mag);
    end

    assign chain_valid[0] = num_v_reg;
    assign chain_rem[0] = zero ? '0 : ext[EXT_W-1:QB];
    assign chain_work[0] = zero ? '0 : ext[QB-1:0];
    assign chain_ctl[0].tag = num_tag_reg;
    assign chain_ctl[0].sat = sat;
    assign chain_ready[NCELL] = dn_ready;

    for (genvar g = 0; g < NCELL; g++)
    begin : g_cell
        dfps_div_cell #(
            .QB(QB)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (chain_valid[g]),
            .up_ready (chain_ready[g]),
            .up_rem   (chain_rem[g]),
            .up_work  (chain_work[g]),
            .up_ctl   (chain_ctl[g]),
            .dn_valid (chain_valid[g+1]),
            .dn_ready (chain_ready[g+1]),
            .dn_rem   (chain_rem[g+1]),
            .dn_work  (chain_work[g+1]),
            .dn_ctl   (chain_ctl[g+1])
        );
    end

    assign dn_valid = chain_valid[NCELL];
    assign dn_value = chain_ctl[NCELL].sat ? {W{1'b1}} : chain_work[NCELL][W-1:0];
    assign dn_tag = chain_ctl[NCELL].tag;

endmodule
`default_nettype wire

// ===== rtl/double_five_point_smoother_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// double_five_point_smoother_unit
// Two cascaded five-point quadratic smoothing stages over a spectrum frame.
// ----------------------------------------------------------------------------
// Within a frame the unit takes one sample per cycle while the output is not
// stalled. At the end of a frame each stage emits the points it held back
// (the last interior points and the two tail points), during which it takes
// no new request. Each stage holds back four points, then adds a numerator
// register and ceil(SAMPLE_BITS/4) divide-by-35 cells, four quotient bits per
// cell. A frame of fewer than five samples gives a single request with
// short_frame and last_out set and smoothed zero; frames of six or seven
// samples give only their first five smoothed points, the fifth carrying
// last_out.
// ----------------------------------------------------------------------------
module double_five_point_smoother_unit #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic                   frame_end,
    output logic                   smoothed_valid,
    input  logic                   smoothed_stall,
    output logic [SAMPLE_BITS-1:0] smoothed,
    output logic                   last_out,
    output logic                   short_frame
);

    logic                   s1_ready;
    dfps_pkg::dfps_tag_t    s1_tag;
    logic                   mid_valid;
    logic                   mid_ready;
    logic [SAMPLE_BITS-1:0] mid_value;
    dfps_pkg::dfps_tag_t    mid_tag;
    dfps_pkg::dfps_tag_t    out_tag;

    assign s1_tag.last = frame_end;
    assign s1_tag.err = 1'b0;
    assign sample_stall = !s1_ready;

    dfps_stage #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .trim     (1'b0),
        .up_valid (sample_valid),
        .up_ready (s1_ready),
        .up_value (sample),
        .up_tag   (s1_tag),
        .dn_valid (mid_valid),
        .dn_ready (mid_ready),
        .dn_value (mid_value),
        .dn_tag   (mid_tag)
    );

    dfps_stage #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .trim     (1'b1),
        .up_valid (mid_valid),
        .up_ready (mid_ready),
        .up_value (mid_value),
        .up_tag   (mid_tag),
        .dn_valid (smoothed_valid),
        .dn_ready (!smoothed_stall),
        .dn_value (smoothed),
        .dn_tag   (out_tag)
    );

    assign last_out = out_tag.last;
    assign short_frame = out_tag.err;

endmodule
`default_nettype wire
